[rtl/ofsd_pkg.sv]
// ofsd_pkg: shared types and constants for the odometry frame speed decoder
// used by ofsd_front, ofsd_fifo, ofsd_back and the top level, depends on nothing
package ofsd_pkg;

   localparam int FRAME_LEN = 34;
   localparam logic [7:0] HEADER_BYTE = 8'hAA;
   localparam logic [7:0] LENGTH_BYTE = 8'd30;
   localparam logic [15:0] MS_PER_MIN = 16'd60000;

   // register indexes on the csr port
   localparam logic REG_MOTOR_CPR = 1'b0;
   localparam logic REG_WHEEL_DIV = 1'b1;

   // fields unpacked from one accepted frame
   typedef struct packed {
      logic [15:0] timestamp;
      logic [31:0] left_count;
      logic [31:0] right_count;
      logic [15:0] yaw_angle;
      logic [15:0] gyro_rate;
   } frame_type;

endpackage

[rtl/ofsd_front.sv]
// ofsd_front: header hunt, byte collection and length check of one frame
// depends on ofsd_pkg
module ofsd_front import ofsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_take,
   input  logic [7:0]  rx_byte,
   output logic        frame_push,
   output frame_type   frame
);

   localparam logic [5:0] LAST_POS = 6'(FRAME_LEN - 1);

   logic [5:0] pos_ff, pos_in;
   logic       len_ok_ff;
   frame_type  frame_ff;
   logic [1:0] lane;

   assign lane = pos_ff[1:0] - 2'd2;
   assign frame = frame_ff;
   assign frame_push = byte_take && pos_ff == LAST_POS && len_ok_ff;

   // position counter, zero means hunting for the header
   always_comb begin
      pos_in = pos_ff;
      if (byte_take) begin
         if (pos_ff == '0) begin
            if (rx_byte == HEADER_BYTE) pos_in = 6'd1;
         end else if (pos_ff == LAST_POS) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // capture the fields as their bytes go by
   always_ff @(posedge clock) begin
      if (byte_take) begin
         case (pos_ff) inside
            6'd2:        len_ok_ff <= (rx_byte == LENGTH_BYTE);
            6'd5:        frame_ff.timestamp[7:0] <= rx_byte;
            6'd6:        frame_ff.timestamp[15:8] <= rx_byte;
            [6'd10:6'd13]: frame_ff.left_count[8*lane +: 8] <= rx_byte;
            [6'd14:6'd17]: frame_ff.right_count[8*lane +: 8] <= rx_byte;
            6'd26:       frame_ff.yaw_angle[7:0] <= rx_byte;
            6'd27:       frame_ff.yaw_angle[15:8] <= rx_byte;
            6'd28:       frame_ff.gyro_rate[7:0] <= rx_byte;
            6'd29:       frame_ff.gyro_rate[15:8] <= rx_byte;
            default: begin
            end
         endcase
      end
   end

endmodule

[rtl/ofsd_fifo.sv]
// ofsd_fifo: two-entry queue of unpacked frames between front and back
// depends on ofsd_pkg
module ofsd_fifo import ofsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  frame_type wr_data,
   output logic      is_full,
   input  logic      rd_en,
   output logic      is_empty,
   output frame_type rd_data
);

   frame_type  mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;

   assign is_full  = cnt_ff == 2'd2;
   assign is_empty = cnt_ff == 2'd0;
   assign rd_data  = mem_ff[rptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wptr_ff] <= wr_data;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (wr_en) wptr_ff <= ~wptr_ff;
         if (rd_en) rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + 2'(wr_en) - 2'(rd_en);
      end
   end

endmodule

[rtl/ofsd_div.sv]
// ofsd_div: signed 48 by unsigned 32 divider, two quotient bits a cycle,
// truncating and saturating to 32 bits signed; depends on nothing
module ofsd_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] num,
   input  logic        [31:0] den,
   output logic               done,
   output logic signed [31:0] quot
);

   logic        busy_ff, done_ff, neg_ff, sat_ff;
   logic [3:0]  cnt_ff;
   logic [31:0] rem_ff, low_ff, q_ff, d_ff;
   logic [47:0] mag;
   logic [32:0] t1, t2;
   logic [31:0] r1, r2;

   assign mag = num[47] ? 48'(-num) : 48'(num);

   // two restoring steps
   always_comb begin
      t1 = {rem_ff, low_ff[31]};
      r1 = (t1 >= {1'b0, d_ff}) ? 32'(t1 - {1'b0, d_ff}) : t1[31:0];
      t2 = {r1, low_ff[30]};
      r2 = (t2 >= {1'b0, d_ff}) ? 32'(t2 - {1'b0, d_ff}) : t2[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            neg_ff  <= num[47];
            sat_ff  <= {16'd0, mag} >= {1'b0, den, 31'd0};
            rem_ff  <= {16'd0, mag[47:32]};
            low_ff  <= mag[31:0];
            d_ff    <= den;
         end else if (busy_ff) begin
            rem_ff <= r2;
            low_ff <= {low_ff[29:0], 2'b00};
            q_ff   <= {q_ff[29:0], t1 >= {1'b0, d_ff}, t2 >= {1'b0, d_ff}};
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // sign and saturation
   always_comb begin
      if (sat_ff) quot = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else        quot = neg_ff ? 32'(-q_ff) : 32'(q_ff);
   end

   assign done = done_ff;

endmodule

[rtl/ofsd_back.sv]
// ofsd_back: deltas, interval, four rpm divisions per timed frame, result register
// depends on ofsd_pkg and ofsd_div
module ofsd_back import ofsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  frame_type          q_data,
   output logic               q_pop,
   input  logic [15:0]        motor_cpr,
   input  logic [15:0]        wheel_div,
   output logic               out_valid,
   input  logic               out_take,
   output logic signed [31:0] left_count,
   output logic signed [31:0] right_count,
   output logic signed [15:0] yaw_angle,
   output logic signed [15:0] gyro_rate,
   output logic signed [31:0] left_motor_rpm,
   output logic signed [31:0] right_motor_rpm,
   output logic signed [31:0] left_wheel_rpm,
   output logic signed [31:0] right_wheel_rpm,
   output logic [15:0]        interval_ms,
   output logic               speeds_valid,
   output logic               zero_interval
);

   typedef enum logic [2:0] {S_IDLE, S_PREP, S_MUL, S_START, S_DIV, S_OUT} state_type;

   state_type   state_ff;
   logic        base_ff, valid_ff, spd_ff, zero_ff;
   frame_type   cur_ff;
   logic [15:0] prev_ts_ff, dt_ff;
   logic [31:0] prev_lc_ff, prev_rc_ff, dl_ff, dr_ff, denm_ff, denw_ff;
   logic signed [47:0] numl_ff, numr_ff;
   logic signed [31:0] rpm_ff [4];
   logic signed [31:0] res [4];
   logic [3:0]  done;
   logic [15:0] mdiv, wdiv;
   logic        out_load;

   assign mdiv  = (motor_cpr == '0) ? 16'd1 : motor_cpr;
   assign wdiv  = (wheel_div == '0) ? 16'd1 : wheel_div;
   assign q_pop = state_ff == S_IDLE && !q_empty;
   assign out_load = state_ff == S_OUT && (!valid_ff || out_take);

   // four dividers run side by side
   ofsd_div u_div_lm (.clock, .reset, .start(state_ff == S_START), .num(numl_ff),
                      .den(denm_ff), .done(done[0]), .quot(res[0]));
   ofsd_div u_div_rm (.clock, .reset, .start(state_ff == S_START), .num(numr_ff),
                      .den(denm_ff), .done(done[1]), .quot(res[1]));
   ofsd_div u_div_lw (.clock, .reset, .start(state_ff == S_START), .num(numl_ff),
                      .den(denw_ff), .done(done[2]), .quot(res[2]));
   ofsd_div u_div_rw (.clock, .reset, .start(state_ff == S_START), .num(numr_ff),
                      .den(denw_ff), .done(done[3]), .quot(res[3]));

   // sequencer, previous-frame state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         base_ff    <= 1'b0;
         valid_ff   <= 1'b0;
         prev_ts_ff <= '0;
         prev_lc_ff <= '0;
         prev_rc_ff <= '0;
      end else begin
         if (out_load) valid_ff <= 1'b1;
         else if (out_take) valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  cur_ff   <= q_data;
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               dt_ff      <= cur_ff.timestamp - prev_ts_ff;
               dl_ff      <= cur_ff.left_count - prev_lc_ff;
               dr_ff      <= cur_ff.right_count - prev_rc_ff;
               spd_ff     <= base_ff;
               zero_ff    <= base_ff && cur_ff.timestamp == prev_ts_ff;
               for (int i = 0; i < 4; i++) rpm_ff[i] <= '0;
               base_ff    <= 1'b1;
               prev_ts_ff <= cur_ff.timestamp;
               prev_lc_ff <= cur_ff.left_count;
               prev_rc_ff <= cur_ff.right_count;
               if (base_ff && cur_ff.timestamp != prev_ts_ff) state_ff <= S_MUL;
               else state_ff <= S_OUT;
            end
            S_MUL: begin
               numl_ff  <= 48'($signed(dl_ff)) * 48'($signed({1'b0, MS_PER_MIN}));
               numr_ff  <= 48'($signed(dr_ff)) * 48'($signed({1'b0, MS_PER_MIN}));
               denm_ff  <= 32'(mdiv) * 32'(dt_ff);
               denw_ff  <= 32'(wdiv) * 32'(dt_ff);
               state_ff <= S_START;
            end
            S_START: state_ff <= S_DIV;
            S_DIV: begin
               if (&done) begin
                  for (int i = 0; i < 4; i++) rpm_ff[i] <= res[i];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  left_count      <= cur_ff.left_count;
                  right_count     <= cur_ff.right_count;
                  yaw_angle       <= cur_ff.yaw_angle;
                  gyro_rate       <= cur_ff.gyro_rate;
                  left_motor_rpm  <= rpm_ff[0];
                  right_motor_rpm <= rpm_ff[1];
                  left_wheel_rpm  <= rpm_ff[2];
                  right_wheel_rpm <= rpm_ff[3];
                  interval_ms     <= spd_ff ? dt_ff : 16'd0;
                  speeds_valid    <= spd_ff;
                  zero_interval   <= zero_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign out_valid = valid_ff;

endmodule

[rtl/odometry_frame_speed_decoder.sv]
// odometry_frame_speed_decoder: top level, csr registers and channel wiring
// depends on ofsd_pkg, ofsd_front, ofsd_fifo, ofsd_back
//
// Usage:
// - req channel: one stream byte per item on req_rx_byte, taken when push is
//   high and full is low. Bytes before the 0xAA header are dropped; a 34-byte
//   frame whose byte 2 is not 30 gives no result.
// - rsp channel: one item per good frame; the oldest result sits on the rsp_
//   ports while empty is low and leaves on pop.
// - csr port: register 0 (motor counts per rev) at 0x0, register 1 (wheel
//   divisor) at 0x4; zero acts as one. Write only while idle.
// - A result passes the queue, then the back end's prepare, multiply, start,
//   divide and output states (four parallel dividers at two quotient bits per
//   cycle); a baseline or zero-interval frame goes from prepare to output.
// - Throughput: one byte per cycle sustained while full stays low; a frame
//   occupies the back end for fewer cycles than its 34 bytes take to arrive.
// - A two-frame queue separates byte collection from the arithmetic; when the
//   receiver stalls, results wait in the output register, the queue fills and
//   full then holds off input.
// - Reset clears the hunt, the baseline and the registers to 1.
module odometry_frame_speed_decoder import ofsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_rx_byte,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_left_count,
   output logic signed [31:0] rsp_right_count,
   output logic signed [15:0] rsp_yaw_angle,
   output logic signed [15:0] rsp_gyro_rate,
   output logic signed [31:0] rsp_left_motor_rpm,
   output logic signed [31:0] rsp_right_motor_rpm,
   output logic signed [31:0] rsp_left_wheel_rpm,
   output logic signed [31:0] rsp_right_wheel_rpm,
   output logic [15:0]        rsp_interval_ms,
   output logic               rsp_speeds_valid,
   output logic               rsp_zero_interval,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [15:0] motor_cpr_ff, wheel_div_ff;
   logic        frame_push, q_full, q_empty, q_pop, out_valid;
   frame_type   frame_w, frame_r;

   // csr registers
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         motor_cpr_ff <= 16'd1;
         wheel_div_ff <= 16'd1;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_MOTOR_CPR: motor_cpr_ff <= pwdata[15:0];
            REG_WHEEL_DIV: wheel_div_ff <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end
   assign prdata = {16'd0, (paddr[2] == REG_WHEEL_DIV) ? wheel_div_ff : motor_cpr_ff};

   assign full  = q_full;
   assign empty = !out_valid;

   ofsd_front u_front (
      .clock, .reset,
      .byte_take(push && !q_full), .rx_byte(req_rx_byte),
      .frame_push, .frame(frame_w)
   );

   ofsd_fifo u_fifo (
      .clock, .reset,
      .wr_en(frame_push), .wr_data(frame_w), .is_full(q_full),
      .rd_en(q_pop), .is_empty(q_empty), .rd_data(frame_r)
   );

   ofsd_back u_back (
      .clock, .reset,
      .q_empty, .q_data(frame_r), .q_pop,
      .motor_cpr(motor_cpr_ff), .wheel_div(wheel_div_ff),
      .out_valid, .out_take(pop && out_valid),
      .left_count(rsp_left_count), .right_count(rsp_right_count),
      .yaw_angle(rsp_yaw_angle), .gyro_rate(rsp_gyro_rate),
      .left_motor_rpm(rsp_left_motor_rpm), .right_motor_rpm(rsp_right_motor_rpm),
      .left_wheel_rpm(rsp_left_wheel_rpm), .right_wheel_rpm(rsp_right_wheel_rpm),
      .interval_ms(rsp_interval_ms), .speeds_valid(rsp_speeds_valid),
      .zero_interval(rsp_zero_interval)
   );

endmodule
